FILE: rtl/bsd_pkg.sv
// ============================================================================
// bsd_pkg: shared definitions for the bitmap symmetric difference block.
// Field widths, action codes, memory word geometry and the word search result.
// ============================================================================
package bsd_pkg;

    localparam int ACTION_W        = 2;
    localparam int VALUE_W         = 10;
    localparam int ELEM_W          = 10;
    localparam int VALUE_RANGE_DEF = 1024;

    // Each memory row holds this many presence bits of set A and of set B.
    localparam int WORD_AW = 4;
    localparam int WORD_W  = 1 << WORD_AW;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ADD_A = 2'd0,
        ACT_ADD_B = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_DRAIN = 2'd3
    } action_t;

    typedef struct packed {
        logic               hit;
        logic [WORD_AW-1:0] bit_idx;
    } find_t;

endpackage

FILE: rtl/bsd_in_if.sv
// ============================================================================
// bsd_in_if: command channel of the bitmap symmetric difference block.
// One beat carries an action and an element value.
// ============================================================================
interface bsd_in_if import bsd_pkg::*; ();

    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [VALUE_W-1:0]  value;

    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);

endinterface

FILE: rtl/bsd_out_if.sv
// ============================================================================
// bsd_out_if: result channel of the bitmap symmetric difference block.
// One beat carries the next element of the symmetric difference or a done flag.
// ============================================================================
interface bsd_out_if import bsd_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [ELEM_W-1:0] element;
    logic              done_res;

    modport source (output valid, output element, output done_res, input ready);
    modport sink   (input valid, input element, input done_res, output ready);

endinterface

FILE: rtl/bsd_word_find.sv
// ============================================================================
// bsd_word_find: lowest differing bit in one memory row.
// Bits below the start offset are ignored.
// ============================================================================
module bsd_word_find import bsd_pkg::*;
(
    input  logic [WORD_W-1:0]  a_word,
    input  logic [WORD_W-1:0]  b_word,
    input  logic [WORD_AW-1:0] start,
    output find_t              find
);

    logic [WORD_W-1:0] diff;

    always_comb
    begin
        diff         = (a_word ^ b_word) & ({WORD_W{1'b1}} << start);
        find.hit     = |diff;
        find.bit_idx = '0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (diff[i])
            begin
                find.bit_idx = WORD_AW'(i);
            end
        end
    end

endmodule

FILE: rtl/bitmap_symmetric_difference_top.sv
// ============================================================================
// bitmap_symmetric_difference_top: symmetric difference of two bitmap sets.
// Adds mark values in set A or B, a clear empties both, and each drain returns
// the next ascending value held in exactly one set, or a done flag.
// ============================================================================
// Both sets live in one synchronous memory of ceil(VALUE_RANGE/16) rows, each
// row holding 16 presence bits of A beside 16 of B, with one read and one write
// port. Commands are handled one at a time. An add reads its row, then writes
// it back with the bit set; an add whose value is not below VALUE_RANGE only
// restarts the scan. A clear zeroes the memory rows one per cycle; the same
// clearing pass runs after reset, and no command is taken until it ends. A
// drain reads one memory row per cycle from the scan position, so its cost is
// set by the distance to the next element held in exactly one set; once the
// scan is exhausted a drain reads no row and returns the done flag. A finished
// result waits in an output register, so commands that cause no result are
// taken while it waits.
module bitmap_symmetric_difference_top import bsd_pkg::*;
#(
    parameter int VALUE_RANGE = VALUE_RANGE_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    bsd_in_if.sink   cmd,
    bsd_out_if.source res
);

    localparam int ROWS  = (VALUE_RANGE + WORD_W - 1) / WORD_W;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int POS_W = WORD_AW + ROW_W + 1;
    localparam int EXT_W = (POS_W > VALUE_W) ? POS_W : VALUE_W;
    localparam logic [POS_W-1:0] POS_END  = POS_W'(VALUE_RANGE);
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_ADD   = 5'b00100,
        S_SCAN  = 5'b01000,
        S_EMIT  = 5'b10000
    } state_t;

    state_t               state_reg,     state_next;
    logic [POS_W-1:0]     scan_pos_reg,  scan_pos_next;
    logic [ROW_W-1:0]     clr_row_reg,   clr_row_next;
    logic                 out_valid_reg, out_valid_next;
    logic [ROW_W-1:0]     add_row_reg,   add_row_next;
    logic [WORD_AW-1:0]   add_bit_reg,   add_bit_next;
    logic                 add_to_b_reg,  add_to_b_next;
    logic [ELEM_W-1:0]    pend_elem_reg, pend_elem_next;
    logic                 pend_done_reg, pend_done_next;
    logic [ELEM_W-1:0]    res_elem_reg;
    logic                 res_done_reg;

    logic [2*WORD_W-1:0]  mem [ROWS];
    logic [2*WORD_W-1:0]  rdata_reg;

    logic                 rd_en;
    logic [ROW_W-1:0]     rd_addr;
    logic                 wr_en;
    logic [ROW_W-1:0]     wr_addr;
    logic [2*WORD_W-1:0]  wr_data;

    logic                 accept;
    logic                 out_free;
    logic                 load;
    logic [EXT_W-1:0]     value_ext;
    logic                 in_range;
    logic [ROW_W-1:0]     in_row;
    logic [WORD_AW-1:0]   in_bit;
    logic [ROW_W-1:0]     scan_row;
    logic [ROW_W-1:0]     nxt_row;
    logic [WORD_W-1:0]    bit_mask;
    logic [POS_W-1:0]     found_pos;
    logic [ELEM_W+POS_W-1:0] found_ext;
    find_t                find;

    bsd_word_find u_word_find
    (
        .a_word (rdata_reg[2*WORD_W-1:WORD_W]),
        .b_word (rdata_reg[WORD_W-1:0]),
        .start  (scan_pos_reg[WORD_AW-1:0]),
        .find   (find)
    );

    assign cmd.ready    = (state_reg == S_IDLE);
    assign res.valid    = out_valid_reg;
    assign res.element  = res_elem_reg;
    assign res.done_res = res_done_reg;

    assign accept    = cmd.valid && cmd.ready;
    assign out_free  = !out_valid_reg || res.ready;
    assign load      = (state_reg == S_EMIT) && out_free;
    assign value_ext = EXT_W'(cmd.value);
    assign in_range  = (value_ext < EXT_W'(VALUE_RANGE));
    assign in_row    = value_ext[WORD_AW+ROW_W-1:WORD_AW];
    assign in_bit    = value_ext[WORD_AW-1:0];
    assign scan_row  = scan_pos_reg[WORD_AW+ROW_W-1:WORD_AW];
    assign nxt_row   = scan_row + 1'b1;
    assign bit_mask  = WORD_W'(1) << add_bit_reg;
    assign found_pos = POS_W'({scan_row, find.bit_idx});
    assign found_ext = {{ELEM_W{1'b0}}, found_pos};

    always_comb
    begin
        state_next     = state_reg;
        scan_pos_next  = scan_pos_reg;
        clr_row_next   = clr_row_reg;
        add_row_next   = add_row_reg;
        add_bit_next   = add_bit_reg;
        add_to_b_next  = add_to_b_reg;
        pend_elem_next = pend_elem_reg;
        pend_done_next = pend_done_reg;
        rd_en          = 1'b0;
        rd_addr        = scan_row;
        wr_en          = 1'b0;
        wr_addr        = clr_row_reg;
        wr_data        = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                wr_en = 1'b1;
                if (clr_row_reg == ROW_LAST)
                begin
                    clr_row_next = '0;
                    state_next   = S_IDLE;
                end
                else
                begin
                    clr_row_next = clr_row_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd.action)
                        ACT_ADD_A, ACT_ADD_B:
                        begin
                            scan_pos_next = '0;
                            if (in_range)
                            begin
                                rd_en         = 1'b1;
                                rd_addr       = in_row;
                                add_row_next  = in_row;
                                add_bit_next  = in_bit;
                                add_to_b_next = (cmd.action == ACT_ADD_B);
                                state_next    = S_ADD;
                            end
                        end
                        ACT_CLEAR:
                        begin
                            scan_pos_next = '0;
                            clr_row_next  = '0;
                            state_next    = S_CLEAR;
                        end
                        ACT_DRAIN:
                        begin
                            if (scan_pos_reg >= POS_END)
                            begin
                                pend_elem_next = '0;
                                pend_done_next = 1'b1;
                                state_next     = S_EMIT;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = scan_row;
                                state_next = S_SCAN;
                            end
                        end
                    endcase
                end
            end
            S_ADD:
            begin
                wr_en   = 1'b1;
                wr_addr = add_row_reg;
                if (add_to_b_reg)
                begin
                    wr_data = rdata_reg | {{WORD_W{1'b0}}, bit_mask};
                end
                else
                begin
                    wr_data = rdata_reg | {bit_mask, {WORD_W{1'b0}}};
                end
                state_next = S_IDLE;
            end
            S_SCAN:
            begin
                if (find.hit)
                begin
                    pend_elem_next = found_ext[ELEM_W-1:0];
                    pend_done_next = 1'b0;
                    scan_pos_next  = found_pos + 1'b1;
                    state_next     = S_EMIT;
                end
                else if (scan_row == ROW_LAST)
                begin
                    pend_elem_next = '0;
                    pend_done_next = 1'b1;
                    scan_pos_next  = POS_END;
                    state_next     = S_EMIT;
                end
                else
                begin
                    scan_pos_next = POS_W'({nxt_row, {WORD_AW{1'b0}}});
                    rd_en         = 1'b1;
                    rd_addr       = nxt_row;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                clr_row_next = '0;
                state_next   = S_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            scan_pos_reg  <= '0;
            clr_row_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_pos_reg  <= scan_pos_next;
            clr_row_reg   <= clr_row_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        add_row_reg   <= add_row_next;
        add_bit_reg   <= add_bit_next;
        add_to_b_reg  <= add_to_b_next;
        pend_elem_reg <= pend_elem_next;
        pend_done_reg <= pend_done_next;
        if (load)
        begin
            res_elem_reg <= pend_elem_reg;
            res_done_reg <= pend_done_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

endmodule

FILE: rtl/bsd_chk.sv
// ============================================================================
// bsd_chk: port-level checks for the bitmap symmetric difference block.
// Bound to the top level; watches only the command and result channels.
// ============================================================================
module bsd_chk import bsd_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                cmd_valid,
    input logic                cmd_ready,
    input logic [ACTION_W-1:0] cmd_action,
    input logic                res_valid,
    input logic                res_ready,
    input logic [ELEM_W-1:0]   res_element,
    input logic                res_done_res
);

    logic cmd_beat;

    assign cmd_beat = cmd_valid && cmd_ready;

    // A result beat that is not taken holds its payload.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_element)
            && $stable(res_done_res))
        else $error("result beat changed while stalled");

    // The done beat carries a zero element.
    a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_done_res |-> res_element == '0)
        else $error("done beat with nonzero element");

    // A drain or a clear keeps the command channel closed in the next cycle.
    a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_beat && (cmd_action == ACT_DRAIN || cmd_action == ACT_CLEAR)
            |=> !cmd_ready)
        else $error("command taken right after a drain or clear");

    // A new result appears only right after the command channel was closed.
    a_res_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(!cmd_ready))
        else $error("result appeared without a drain in progress");

endmodule

bind bitmap_symmetric_difference_top bsd_chk u_bsd_chk
(
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd_valid    (cmd.valid),
    .cmd_ready    (cmd.ready),
    .cmd_action   (cmd.action),
    .res_valid    (res.valid),
    .res_ready    (res.ready),
    .res_element  (res.element),
    .res_done_res (res.done_res)
);
